### src/dpwp_pkg.sv
// shared widths, register indexes and reset values for the depth to world point unit
`default_nettype none
package dpwp_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned DEPTH_W        = 19;
  localparam int unsigned WORLD_W        = 20;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned ROT_W          = 48;
  localparam int unsigned VEC_W          = 60;
  localparam int unsigned HOR_W          = 40;
  localparam int unsigned CX_W           = 12;
  localparam int unsigned INV_W          = 20;
  localparam int unsigned RENT_W         = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_ORIGIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTRINSICS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VEHICLE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZON_SQ = 3'd6;

  // identity rotation in q1.14
  localparam logic [ROT_W-1:0] ROT_ROW0_RST = 48'h0000_0000_4000;
  localparam logic [ROT_W-1:0] ROT_ROW1_RST = 48'h0000_4000_0000;
  localparam logic [ROT_W-1:0] ROT_ROW2_RST = 48'h4000_0000_0000;

  localparam logic signed [WORLD_W-1:0] WORLD_MAX = 20'sh7FFFF;
  localparam logic signed [WORLD_W-1:0] WORLD_MIN = 20'sh80000;

endpackage
`default_nettype wire

### src/dpwp_if.sv
// valid/ready channels for depth pixels in and world points out
`default_nettype none
interface dpwp_pix_if #(
  parameter int unsigned COORD_BITS = dpwp_pkg::COORD_BITS_DEF
);
  import dpwp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_col;
  logic [COORD_BITS-1:0] pixel_row;
  logic [DEPTH_W-1:0]    depth_mm;

  modport source (output valid, output pixel_col, output pixel_row, output depth_mm,
                  input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, input depth_mm,
                  output ready);
endinterface

interface dpwp_pt_if;
  import dpwp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      point_valid;
  logic signed [WORLD_W-1:0] world_x;
  logic signed [WORLD_W-1:0] world_y;
  logic signed [WORLD_W-1:0] world_z;

  modport source (output valid, output point_valid, output world_x, output world_y,
                  output world_z, input ready);
  modport sink   (input valid, input point_valid, input world_x, input world_y,
                  input world_z, output ready);
endinterface
`default_nettype wire

### src/depth_pixel_to_world_point_unit.sv
// pinhole back-projection of a depth pixel into a horizon-gated world point
// throughput: one pixel per cycle while the output is ready; each of the 8 stages holds under back-pressure
//   and refills as soon as the stage after it moves, so bubbles are squeezed out
// reset: all stage valids clear, configuration registers return to identity rotation and zeros
`default_nettype none
module depth_pixel_to_world_point_unit #(
  parameter int unsigned COORD_BITS = dpwp_pkg::COORD_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  dpwp_pix_if.sink                                  pix_in,
  dpwp_pt_if.source                                 pt_out,
  input  wire logic                                 cfg_we_i,
  input  wire logic [dpwp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [dpwp_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import dpwp_pkg::*;

  localparam int unsigned NS     = 8;
  localparam int unsigned DU_W   = ((COORD_BITS > CX_W) ? COORD_BITS : CX_W) + 1;
  localparam int unsigned DF_W   = DEPTH_W + INV_W;
  localparam int unsigned PROD_W = DU_W + DF_W + 1;
  localparam int unsigned CAM_W  = PROD_W - 20;
  localparam int unsigned PR_W   = CAM_W + RENT_W;
  localparam int unsigned SUM_W  = PR_W + 2;
  localparam int unsigned RND_W  = SUM_W - 14;
  localparam int unsigned W_W    = RND_W + 1;
  localparam int unsigned D_W    = W_W + 1;
  localparam int unsigned SQ_W   = 2 * WORLD_W;
  localparam int unsigned DIST_W = SQ_W + 2;

  localparam logic signed [PROD_W:0] HALF20 = {{(PROD_W-19){1'b0}}, 1'b1, 19'b0};
  localparam logic signed [SUM_W-1:0] HALF14 = {{(SUM_W-14){1'b0}}, 1'b1, 13'b0};

  // ---------------- configuration registers
  logic [ROT_W-1:0]   rot_q [3];
  logic [VEC_W-1:0]   org_q;
  logic [63:0]        intr_q;
  logic [VEC_W-1:0]   veh_q;
  logic [HOR_W-1:0]   hor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= ROT_ROW0_RST;
      rot_q[1] <= ROT_ROW1_RST;
      rot_q[2] <= ROT_ROW2_RST;
      org_q    <= '0;
      intr_q   <= '0;
      veh_q    <= '0;
      hor_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROT_ROW0:   rot_q[0] <= cfg_wdata_i[ROT_W-1:0];
        REG_ROT_ROW1:   rot_q[1] <= cfg_wdata_i[ROT_W-1:0];
        REG_ROT_ROW2:   rot_q[2] <= cfg_wdata_i[ROT_W-1:0];
        REG_CAM_ORIGIN: org_q    <= cfg_wdata_i[VEC_W-1:0];
        REG_INTRINSICS: intr_q   <= cfg_wdata_i;
        REG_VEHICLE:    veh_q    <= cfg_wdata_i[VEC_W-1:0];
        REG_HORIZON_SQ: hor_q    <= cfg_wdata_i[HOR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CX_W-1:0]  cx, cy;
  logic [INV_W-1:0] ifx, ify;
  assign cx  = intr_q[11:0];
  assign cy  = intr_q[23:12];
  assign ifx = intr_q[43:24];
  assign ify = intr_q[63:44];

  // ---------------- stage control
  logic [NS-1:0] v_q;
  logic [NS:0]   adv;

  always_comb begin
    adv[NS] = pt_out.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign pix_in.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= pix_in.valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // zero-depth flag rides along all stages
  logic [NS-1:0] zr_q;
  always_ff @(posedge clk_i) begin
    if (adv[0]) zr_q[0] <= (pix_in.depth_mm == '0);
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) zr_q[k] <= zr_q[k-1];
    end
  end

  // ---------------- s0: offsets from principal point, depth times reciprocals
  logic signed [DU_W-1:0] dux_q, duy_q;
  logic [DF_W-1:0]        dfx_q, dfy_q;
  logic [DEPTH_W-1:0]     d0_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dux_q <= $signed({{(DU_W-COORD_BITS){1'b0}}, pix_in.pixel_col})
             - $signed({{(DU_W-CX_W){1'b0}}, cx});
      duy_q <= $signed({{(DU_W-COORD_BITS){1'b0}}, pix_in.pixel_row})
             - $signed({{(DU_W-CX_W){1'b0}}, cy});
      dfx_q <= {{INV_W{1'b0}}, pix_in.depth_mm} * {{DEPTH_W{1'b0}}, ifx};
      dfy_q <= {{INV_W{1'b0}}, pix_in.depth_mm} * {{DEPTH_W{1'b0}}, ify};
      d0_q  <= pix_in.depth_mm;
    end
  end

  // ---------------- s1: full products
  logic signed [PROD_W-1:0] px_q, py_q;
  logic [DEPTH_W-1:0]       d1_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      px_q <= dux_q * $signed({1'b0, dfx_q});
      py_q <= duy_q * $signed({1'b0, dfy_q});
      d1_q <= d0_q;
    end
  end

  // ---------------- s2: round half up to camera millimetres
  logic signed [PROD_W:0]  rx, ry;
  logic signed [CAM_W-1:0] cam_q [3];

  assign rx = $signed({px_q[PROD_W-1], px_q}) + HALF20;
  assign ry = $signed({py_q[PROD_W-1], py_q}) + HALF20;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      cam_q[0] <= rx[PROD_W-1:20];
      cam_q[1] <= ry[PROD_W-1:20];
      cam_q[2] <= $signed({{(CAM_W-DEPTH_W){1'b0}}, d1_q});
    end
  end

  // ---------------- s3: nine rotation products
  logic signed [PR_W-1:0] pr_q [3][3];

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr_q[i][j] <= $signed(rot_q[i][RENT_W*j +: RENT_W]) * cam_q[j];
        end
      end
    end
  end

  // ---------------- s4: row sums, round by 2^14
  logic signed [SUM_W-1:0] rs [3];
  logic signed [RND_W-1:0] rnd_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs[i] = $signed({{2{pr_q[i][0][PR_W-1]}}, pr_q[i][0]})
            + $signed({{2{pr_q[i][1][PR_W-1]}}, pr_q[i][1]})
            + $signed({{2{pr_q[i][2][PR_W-1]}}, pr_q[i][2]})
            + HALF14;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      for (int i = 0; i < 3; i++) rnd_q[i] <= rs[i][SUM_W-1:14];
    end
  end

  // ---------------- s5: translate, offset from vehicle
  logic signed [W_W-1:0] w_q [3];
  logic signed [D_W-1:0] df_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      for (int i = 0; i < 3; i++) begin
        w_q[i]  <= $signed({rnd_q[i][RND_W-1], rnd_q[i]})
                 + $signed({{(W_W-WORLD_W){org_q[WORLD_W*i+WORLD_W-1]}},
                            org_q[WORLD_W*i +: WORLD_W]});
        df_q[i] <= $signed({{2{rnd_q[i][RND_W-1]}}, rnd_q[i]})
                 + $signed({{(D_W-WORLD_W){org_q[WORLD_W*i+WORLD_W-1]}},
                            org_q[WORLD_W*i +: WORLD_W]})
                 - $signed({{(D_W-WORLD_W){veh_q[WORLD_W*i+WORLD_W-1]}},
                            veh_q[WORLD_W*i +: WORLD_W]});
      end
    end
  end

  // ---------------- s6: squares, range flags, saturation
  logic [D_W-1:0]               ad [3];
  logic [2:0]                   ovf;
  logic signed [WORLD_W-1:0]    ws [3];
  logic [SQ_W-1:0]              sq_q [3];
  logic                         far_q;
  logic signed [WORLD_W-1:0]    ws_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ad[i]  = df_q[i][D_W-1] ? D_W'(-df_q[i]) : D_W'(df_q[i]);
      ovf[i] = !((&w_q[i][W_W-1:WORLD_W-1]) || !(|w_q[i][W_W-1:WORLD_W-1]));
      if (ovf[i]) begin
        ws[i] = w_q[i][W_W-1] ? WORLD_MIN : WORLD_MAX;
      end else begin
        ws[i] = w_q[i][WORLD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= {{WORLD_W{1'b0}}, ad[i][WORLD_W-1:0]}
                 * {{WORLD_W{1'b0}}, ad[i][WORLD_W-1:0]};
        ws_q[i] <= ws[i];
      end
      far_q <= (|ad[0][D_W-1:WORLD_W]) || (|ad[1][D_W-1:WORLD_W])
            || (|ad[2][D_W-1:WORLD_W]);
    end
  end

  // ---------------- s7: horizon test, output register
  logic [DIST_W-1:0]         dist_sq;
  logic                      keep;
  logic                      pv_q;
  logic signed [WORLD_W-1:0] wo_q [3];

  assign dist_sq = {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
  assign keep = !zr_q[6] && !far_q && (dist_sq <= {{(DIST_W-HOR_W){1'b0}}, hor_q});

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      pv_q <= keep;
      for (int i = 0; i < 3; i++) wo_q[i] <= keep ? ws_q[i] : '0;
    end
  end

  assign pt_out.valid       = v_q[NS-1];
  assign pt_out.point_valid = pv_q;
  assign pt_out.world_x     = wo_q[0];
  assign pt_out.world_y     = wo_q[1];
  assign pt_out.world_z     = wo_q[2];

  // zero-depth beats are carried but never marked as kept
  logic unused_zr;
  assign unused_zr = zr_q[NS-1];

  // ---------------- checks
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NS-1] |-> pix_in.ready)
    else $error("input not ready although the output stage is empty");

  a_accept_fills_s0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_in.valid && pix_in.ready) |=> v_q[0])
    else $error("accepted beat did not enter the first stage");

  a_drop_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_out.valid && !pt_out.point_valid) |->
      (pt_out.world_x == '0 && pt_out.world_y == '0 && pt_out.world_z == '0))
    else $error("dropped point carries nonzero coordinates");

  a_zero_depth_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_out.valid && unused_zr) |-> !pt_out.point_valid)
    else $error("zero-depth pixel produced a kept point");

endmodule
`default_nettype wire
